// ===== rtl/core/tpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trail point queue package
// Shared field widths, item and register codes, register reset values, and the
// status bundle of the distance unit.
// ----------------------------------------------------------------------------
package tpq_pkg;

  localparam int Q_W       = 32;  // Q16.16 coordinates, ages and times
  localparam int COUNT_W   = 6;   // live_count and dropped_count fields
  localparam int INDEX_W   = 5;   // read_index field
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int MIN_POINTS = 2;

  // Item kinds.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_POINTS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EMIT_ENABLE  = 2'd3;

  // Configuration reset values.
  localparam logic [Q_W-1:0]     LIFETIME_RST     = '0;
  localparam logic [Q_W-1:0]     MIN_DISTANCE_RST = '0;
  localparam logic [COUNT_W-1:0] MAX_POINTS_RST   = 6'd32;
  localparam logic               EMIT_ENABLE_RST  = 1'b1;

  typedef struct packed {
    logic done;  // one-cycle pulse when the comparison is ready
    logic far;   // squared distance is at least the squared minimum
  } dist_status_t;

endpackage

// ===== rtl/core/tpq_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trail point queue input channel
// Valid/ready channel that carries tick and read items.
// ----------------------------------------------------------------------------
interface tpq_in_if import tpq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [Q_W-1:0]     pos_x;
  logic signed [Q_W-1:0]     pos_y;
  logic signed [Q_W-1:0]     pos_z;
  logic        [Q_W-1:0]     delta_time;
  logic        [INDEX_W-1:0] read_index;

  modport source (output valid, kind, pos_x, pos_y, pos_z, delta_time, read_index,
                  input ready);
  modport sink (input valid, kind, pos_x, pos_y, pos_z, delta_time, read_index,
                output ready);
endinterface

// ----------------------------------------------------------------------------
// Trail point queue result channel
// Valid/ready channel that carries one result per item.
// ----------------------------------------------------------------------------
interface tpq_out_if import tpq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [COUNT_W-1:0] live_count;
  logic                      emitted;
  logic        [COUNT_W-1:0] dropped_count;
  logic signed [Q_W-1:0]     point_x;
  logic signed [Q_W-1:0]     point_y;
  logic signed [Q_W-1:0]     point_z;
  logic        [Q_W-1:0]     point_age;
  logic                      point_valid;

  modport source (output valid, live_count, emitted, dropped_count, point_x, point_y,
                  point_z, point_age, point_valid, input ready);
  modport sink (input valid, live_count, emitted, dropped_count, point_x, point_y,
                point_z, point_age, point_valid, output ready);
endinterface

// ===== rtl/core/tpq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trail point queue RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tpq_dist.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trail point queue distance unit
// Compares the squared distance to the last emitted point with the squared
// minimum distance, one square per cycle through a shared multiplier.
// ----------------------------------------------------------------------------
module tpq_dist import tpq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [Q_W-1:0] pos_x_i,
  input  logic signed [Q_W-1:0] pos_y_i,
  input  logic signed [Q_W-1:0] pos_z_i,
  input  logic signed [Q_W-1:0] last_x_i,
  input  logic signed [Q_W-1:0] last_y_i,
  input  logic signed [Q_W-1:0] last_z_i,
  input  logic        [Q_W-1:0] min_dist_i,
  output dist_status_t          status_o
);

  typedef enum logic [1:0] {
    TERM_X,
    TERM_Y,
    TERM_Z,
    TERM_MIN
  } term_e;

  logic             busy_q;
  term_e            step_q;
  logic [Q_W-1:0]   op_q;
  logic             op_v_q;
  term_e            op_term_q;
  logic [2*Q_W-1:0] prod_q;
  logic             prod_v_q;
  term_e            prod_term_q;
  logic [2*Q_W-1:0] sum_q;
  logic             done_q;
  logic             far_q;
  logic [Q_W-1:0]   op_d;
  logic [2*Q_W:0]   acc;

  // The difference of two signed 32-bit values has a magnitude below 2^32.
  function automatic logic [Q_W-1:0] abs_diff(input logic signed [Q_W-1:0] a,
                                               input logic signed [Q_W-1:0] b);
    logic signed [Q_W:0] d;
    logic signed [Q_W:0] n;
    d = {a[Q_W-1], a} - {b[Q_W-1], b};
    n = -d;
    return d[Q_W] ? n[Q_W-1:0] : d[Q_W-1:0];
  endfunction

  always_comb begin
    unique case (step_q)
      TERM_X:   op_d = abs_diff(pos_x_i, last_x_i);
      TERM_Y:   op_d = abs_diff(pos_y_i, last_y_i);
      TERM_Z:   op_d = abs_diff(pos_z_i, last_z_i);
      TERM_MIN: op_d = min_dist_i;
      default:  op_d = min_dist_i;
    endcase
  end

  assign acc = {1'b0, sum_q} + {1'b0, prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= TERM_X;
      op_v_q      <= 1'b0;
      op_term_q   <= TERM_X;
      prod_v_q    <= 1'b0;
      prod_term_q <= TERM_X;
      sum_q       <= '0;
      done_q      <= 1'b0;
      far_q       <= 1'b0;
    end else begin
      done_q   <= 1'b0;
      op_v_q   <= busy_q;
      prod_v_q <= op_v_q;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= TERM_X;
        sum_q  <= '0;
      end else if (busy_q) begin
        op_term_q <= step_q;
        if (step_q == TERM_MIN) begin
          busy_q <= 1'b0;
        end else begin
          step_q <= term_e'(step_q + 2'd1);
        end
      end
      if (op_v_q) begin
        prod_term_q <= op_term_q;
      end
      if (prod_v_q) begin
        if (prod_term_q == TERM_MIN) begin
          done_q <= 1'b1;
          far_q  <= (sum_q >= prod_q);
        end else begin
          sum_q <= acc[2*Q_W] ? '1 : acc[2*Q_W-1:0];
        end
      end
    end
  end

  // Operand and product registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      op_q <= op_d;
    end
    if (op_v_q) begin
      prod_q <= op_q * op_q;
    end
  end

  assign status_o = '{done: done_q, far: far_q};

endmodule

// ===== rtl/core/trail_point_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trail point queue
// Oldest-first ring of trail points held in on-chip memories.
// ----------------------------------------------------------------------------
// The block holds up to CAPACITY points in a ring kept in two memories, one
// for positions and one for ages. One item is in work at a time. A tick sweeps
// the age memory once, one read and one write back per cycle, and counts the
// expired leading points on the way. With emission on, it then runs a
// four-square distance check through a single 32x32 multiplier and appends
// the point when it is far enough or no point was emitted yet; every tick
// then trims. A read of an index past the live points skips the memory read.
// The next item is taken while the previous result waits on the output.
// ----------------------------------------------------------------------------
module trail_point_queue import tpq_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tpq_in_if.sink                item_i,
  tpq_out_if.source             result_o
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int HW  = $clog2(CAPACITY + 1);
  localparam int DW  = HW + 1;
  localparam int SW  = HW + 1;
  localparam int CW  = (HW > COUNT_W) ? HW : COUNT_W;
  localparam int POS_W = 3 * Q_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_SWEEP,
    ST_DIST,
    ST_APPEND,
    ST_TRIM,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;

  logic [Q_W-1:0]     lifetime_q;
  logic [Q_W-1:0]     min_dist_q;
  logic [COUNT_W-1:0] max_points_q;
  logic               emit_en_q;

  logic [HW-1:0] held_q, held_d;
  logic [AW-1:0] oldest_q, oldest_d;
  logic          has_last_q, has_last_d;
  logic signed [Q_W-1:0] last_x_q, last_x_d, last_y_q, last_y_d, last_z_q, last_z_d;

  logic signed [Q_W-1:0] px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic [Q_W-1:0]        dt_q, dt_d;
  logic                  pvalid_q, pvalid_d;

  logic [AW-1:0] iss_slot_q, iss_slot_d;
  logic [HW-1:0] issue_cnt_q, issue_cnt_d;
  logic          pending_q, pending_d;
  logic [AW-1:0] wb_slot_q, wb_slot_d;
  logic [HW-1:0] exp_cnt_q, exp_cnt_d;
  logic          prefix_q, prefix_d;
  logic [DW-1:0] dropped_q, dropped_d;
  logic          emitted_q, emitted_d;

  logic                  out_valid_q, out_valid_d;
  logic [COUNT_W-1:0]    out_live_q, out_live_d;
  logic                  out_emitted_q, out_emitted_d;
  logic [COUNT_W-1:0]    out_dropped_q, out_dropped_d;
  logic signed [Q_W-1:0] out_x_q, out_x_d, out_y_q, out_y_d, out_z_q, out_z_d;
  logic [Q_W-1:0]        out_age_q, out_age_d;
  logic                  out_pvalid_q, out_pvalid_d;

  logic             age_we, age_re, pos_we, pos_re;
  logic [AW-1:0]    age_waddr, pos_waddr, raddr;
  logic [Q_W-1:0]   age_wdata, age_rdata;
  logic [POS_W-1:0] pos_rdata;

  logic          dist_start;
  dist_status_t  dist_st;

  logic          in_accept;
  logic [CW-1:0] ridx_ext;
  logic [AW-1:0] read_slot;
  logic [AW-1:0] append_slot;

  // Adds an offset to a ring slot; the sum always stays below twice the depth.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [HW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s >= SW'(CAPACITY)) begin
      s = s - SW'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [Q_W-1:0] sat_age(input logic [Q_W-1:0] a, input logic [Q_W-1:0] b);
    logic [Q_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[Q_W] ? '1 : s[Q_W-1:0];
  endfunction

  assign item_i.ready = (state_q == ST_IDLE);
  assign in_accept    = item_i.valid && item_i.ready;
  assign ridx_ext     = CW'(item_i.read_index);
  assign read_slot    = wrap_add(oldest_q, HW'(item_i.read_index));
  assign append_slot  = wrap_add(oldest_q, held_q);
  assign raddr        = (state_q == ST_SWEEP) ? iss_slot_q : read_slot;

  always_comb begin
    logic [Q_W-1:0] new_age;
    logic [CW-1:0]  cap;
    logic [HW-1:0]  excess;

    state_d     = state_q;
    held_d      = held_q;
    oldest_d    = oldest_q;
    has_last_d  = has_last_q;
    last_x_d    = last_x_q;
    last_y_d    = last_y_q;
    last_z_d    = last_z_q;
    px_d        = px_q;
    py_d        = py_q;
    pz_d        = pz_q;
    dt_d        = dt_q;
    pvalid_d    = pvalid_q;
    iss_slot_d  = iss_slot_q;
    issue_cnt_d = issue_cnt_q;
    pending_d   = pending_q;
    wb_slot_d   = wb_slot_q;
    exp_cnt_d   = exp_cnt_q;
    prefix_d    = prefix_q;
    dropped_d   = dropped_q;
    emitted_d   = emitted_q;

    out_valid_d   = out_valid_q && !result_o.ready;
    out_live_d    = out_live_q;
    out_emitted_d = out_emitted_q;
    out_dropped_d = out_dropped_q;
    out_x_d       = out_x_q;
    out_y_d       = out_y_q;
    out_z_d       = out_z_q;
    out_age_d     = out_age_q;
    out_pvalid_d  = out_pvalid_q;

    age_we     = 1'b0;
    age_waddr  = wb_slot_q;
    age_wdata  = '0;
    age_re     = 1'b0;
    pos_we     = 1'b0;
    pos_re     = 1'b0;
    pos_waddr  = append_slot;
    dist_start = 1'b0;

    new_age = sat_age(age_rdata, dt_q);
    cap     = (max_points_q < COUNT_W'(MIN_POINTS)) ? CW'(MIN_POINTS) : CW'(max_points_q);
    if (cap > CW'(CAPACITY)) begin
      cap = CW'(CAPACITY);
    end
    excess = held_q - HW'(cap);

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          px_d      = item_i.pos_x;
          py_d      = item_i.pos_y;
          pz_d      = item_i.pos_z;
          dt_d      = item_i.delta_time;
          dropped_d = '0;
          emitted_d = 1'b0;
          if (item_i.kind == KIND_READ) begin
            pvalid_d = ridx_ext < CW'(held_q);
            age_re   = pvalid_d;
            pos_re   = pvalid_d;
            state_d  = pvalid_d ? ST_RD_WAIT : ST_RESULT;
          end else begin
            pvalid_d    = 1'b0;
            iss_slot_d  = oldest_q;
            issue_cnt_d = '0;
            pending_d   = 1'b0;
            exp_cnt_d   = '0;
            prefix_d    = 1'b1;
            state_d     = ST_SWEEP;
          end
        end
      end
      ST_RD_WAIT: begin
        state_d = ST_RESULT;
      end
      ST_SWEEP: begin
        // Reads run one slot ahead of the write back, so the two never meet.
        if (issue_cnt_q != held_q) begin
          age_re      = 1'b1;
          iss_slot_d  = wrap_add(iss_slot_q, HW'(1));
          issue_cnt_d = issue_cnt_q + HW'(1);
          wb_slot_d   = iss_slot_q;
          pending_d   = 1'b1;
        end else begin
          pending_d = 1'b0;
        end
        if (pending_q) begin
          age_we    = 1'b1;
          age_wdata = new_age;
          // Only an unbroken run of expired points from the oldest is dropped.
          if (prefix_q && (lifetime_q != '0) && (new_age > lifetime_q)) begin
            exp_cnt_d = exp_cnt_q + HW'(1);
          end else begin
            prefix_d = 1'b0;
          end
        end
        if ((issue_cnt_q == held_q) && !pending_q) begin
          held_d    = held_q - exp_cnt_q;
          oldest_d  = wrap_add(oldest_q, exp_cnt_q);
          dropped_d = DW'(exp_cnt_q);
          if (emit_en_q) begin
            dist_start = 1'b1;
            state_d    = ST_DIST;
          end else begin
            state_d = ST_TRIM;
          end
        end
      end
      ST_DIST: begin
        if (dist_st.done) begin
          state_d = (!has_last_q || dist_st.far) ? ST_APPEND : ST_TRIM;
        end
      end
      ST_APPEND: begin
        // A full ring overwrites its oldest slot, which is where the new point lands.
        age_we    = 1'b1;
        age_waddr = append_slot;
        age_wdata = '0;
        pos_we    = 1'b1;
        if (held_q == HW'(CAPACITY)) begin
          oldest_d  = wrap_add(oldest_q, HW'(1));
          dropped_d = dropped_q + DW'(1);
        end else begin
          held_d = held_q + HW'(1);
        end
        last_x_d   = px_q;
        last_y_d   = py_q;
        last_z_d   = pz_q;
        has_last_d = 1'b1;
        emitted_d  = 1'b1;
        state_d    = ST_TRIM;
      end
      ST_TRIM: begin
        if (CW'(held_q) > cap) begin
          dropped_d = dropped_q + DW'(excess);
          oldest_d  = wrap_add(oldest_q, excess);
          held_d    = HW'(cap);
        end
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d   = 1'b1;
          out_live_d    = COUNT_W'(held_q);
          out_emitted_d = emitted_q;
          out_dropped_d = COUNT_W'(dropped_q);
          out_pvalid_d  = pvalid_q;
          if (pvalid_q) begin
            out_x_d   = pos_rdata[3*Q_W-1:2*Q_W];
            out_y_d   = pos_rdata[2*Q_W-1:Q_W];
            out_z_d   = pos_rdata[Q_W-1:0];
            out_age_d = age_rdata;
          end else begin
            out_x_d   = '0;
            out_y_d   = '0;
            out_z_d   = '0;
            out_age_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      lifetime_q   <= LIFETIME_RST;
      min_dist_q   <= MIN_DISTANCE_RST;
      max_points_q <= MAX_POINTS_RST;
      emit_en_q    <= EMIT_ENABLE_RST;
      held_q       <= '0;
      oldest_q     <= '0;
      has_last_q   <= 1'b0;
      last_x_q     <= '0;
      last_y_q     <= '0;
      last_z_q     <= '0;
      issue_cnt_q  <= '0;
      pending_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      oldest_q    <= oldest_d;
      has_last_q  <= has_last_d;
      last_x_q    <= last_x_d;
      last_y_q    <= last_y_d;
      last_z_q    <= last_z_d;
      issue_cnt_q <= issue_cnt_d;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LIFETIME:     lifetime_q   <= cfg_data_i[Q_W-1:0];
          CFG_MIN_DISTANCE: min_dist_q   <= cfg_data_i[Q_W-1:0];
          CFG_MAX_POINTS:   max_points_q <= cfg_data_i[COUNT_W-1:0];
          CFG_EMIT_ENABLE:  emit_en_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // Item, sweep and result payload registers.
  always_ff @(posedge clk_i) begin
    px_q          <= px_d;
    py_q          <= py_d;
    pz_q          <= pz_d;
    dt_q          <= dt_d;
    pvalid_q      <= pvalid_d;
    iss_slot_q    <= iss_slot_d;
    wb_slot_q     <= wb_slot_d;
    exp_cnt_q     <= exp_cnt_d;
    prefix_q      <= prefix_d;
    dropped_q     <= dropped_d;
    emitted_q     <= emitted_d;
    out_live_q    <= out_live_d;
    out_emitted_q <= out_emitted_d;
    out_dropped_q <= out_dropped_d;
    out_x_q       <= out_x_d;
    out_y_q       <= out_y_d;
    out_z_q       <= out_z_d;
    out_age_q     <= out_age_d;
    out_pvalid_q  <= out_pvalid_d;
  end

  tpq_ram #(
    .WIDTH (Q_W),
    .DEPTH (CAPACITY)
  ) u_age_ram (
    .clk_i   (clk_i),
    .we_i    (age_we),
    .waddr_i (age_waddr),
    .wdata_i (age_wdata),
    .re_i    (age_re),
    .raddr_i (raddr),
    .rdata_o (age_rdata)
  );

  tpq_ram #(
    .WIDTH (POS_W),
    .DEPTH (CAPACITY)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i ({px_q, py_q, pz_q}),
    .re_i    (pos_re),
    .raddr_i (raddr),
    .rdata_o (pos_rdata)
  );

  tpq_dist u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dist_start),
    .pos_x_i    (px_q),
    .pos_y_i    (py_q),
    .pos_z_i    (pz_q),
    .last_x_i   (last_x_q),
    .last_y_i   (last_y_q),
    .last_z_i   (last_z_q),
    .min_dist_i (min_dist_q),
    .status_o   (dist_st)
  );

  assign result_o.valid         = out_valid_q;
  assign result_o.live_count    = out_live_q;
  assign result_o.emitted       = out_emitted_q;
  assign result_o.dropped_count = out_dropped_q;
  assign result_o.point_x       = out_x_q;
  assign result_o.point_y       = out_y_q;
  assign result_o.point_z       = out_z_q;
  assign result_o.point_age     = out_age_q;
  assign result_o.point_valid   = out_pvalid_q;

  // The ring never holds more points than it has slots.
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= HW'(CAPACITY))
    else $error("held point count exceeds the capacity");

  // During the sweep the write back never targets the slot being read.
  a_sweep_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (age_we && age_re) |-> (age_waddr != raddr))
    else $error("age memory read and write hit the same slot");

  // An append always leaves a last emitted position behind.
  a_append_sets_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPEND) |=> has_last_q && emitted_q)
    else $error("append did not record the emitted position");

endmodule
